// File: sv/bmf_pkg.sv
// bmf_pkg: shared constants, types and helpers of the 3x3 box mean filter
// depends on nothing; used by every module of the block
package bmf_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int DIM_BITS   = 11;
    localparam int PIX_BITS   = 8;
    localparam int LINE_COUNT = 2;
    localparam int WORD_BITS  = PIX_BITS * LINE_COUNT;
    localparam int CSUM_BITS  = 10;
    localparam int SUM_BITS   = 12;
    localparam int PROD_BITS  = 24;
    localparam int RECIP_SHIFT = 15;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = FIFO_AW + 1;
    localparam int TDATA_BITS = 32;

    // floor(x/9) == (x*3641)>>15 for every x below 2^15
    localparam logic [SUM_BITS-1:0] RECIP_NINTH = SUM_BITS'(3641);
    localparam logic [SUM_BITS-1:0] ROUND_HALF  = SUM_BITS'(4);

    localparam logic [DIM_BITS-1:0] DIM_MIN   = DIM_BITS'(3);
    localparam logic [DIM_BITS-1:0] WIDTH_MAX = DIM_BITS'(MAX_COLS);
    localparam logic [DIM_BITS-1:0] HEIGHT_MAX = DIM_BITS'(MAX_ROWS);
    localparam logic [DIM_BITS-1:0] WIDTH_RST  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RST = DIM_BITS'(480);

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // pixel accepted and routed to the window stage
    typedef struct packed {
        logic                 vld;
        logic [PIX_BITS-1:0]  pix;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic                 has_res;
        logic                 last;
        logic                 fwd;
        logic [WORD_BITS-1:0] fwd_data;
    } t_s1;

    typedef struct packed {
        logic                 en;
        logic [COL_BITS-1:0]  addr;
        logic [WORD_BITS-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic                frame_done;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic [PIX_BITS-1:0] mean;
    } t_result;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] maxv);
        logic [DIM_BITS-1:0] res;
        res = v;
        if (v < DIM_MIN) begin
            res = DIM_MIN;
        end else if (v > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

endpackage

// File: sv/bmf_line_mem.sv
// bmf_line_mem: two-line store, one word per column holding the two rows above
// depends on bmf_pkg; synchronous write, registered read
module bmf_line_mem
    import bmf_pkg::*;
(
    input  logic                 i_clk,
    input  t_mem_wr              i_wr,
    input  logic                 i_rd_en,
    input  logic [COL_BITS-1:0]  i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [MAX_COLS];
    logic [WORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/bmf_window.sv
// bmf_window: column assembly, line store write back, window sum and divide by nine
// depends on bmf_pkg; fed by the accept stage and the line store read port
module bmf_window
    import bmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_s1                  i_s1,
    input  logic [WORD_BITS-1:0] i_rd_data,
    output t_mem_wr              o_mem_wr,
    output logic                 o_push,
    output t_result              o_res
);

    logic [WORD_BITS-1:0] word;
    logic [PIX_BITS-1:0]  above1;
    logic [PIX_BITS-1:0]  above2;
    logic [CSUM_BITS-1:0] col_sum;

    logic [CSUM_BITS-1:0] r_cs0;
    logic [CSUM_BITS-1:0] r_cs1;

    logic                 r_c_vld;
    logic [SUM_BITS-1:0]  r_c_sum;
    logic [ROW_BITS-1:0]  r_c_row;
    logic [COL_BITS-1:0]  r_c_col;
    logic                 r_c_last;

    logic                 r_d_vld;
    logic [PROD_BITS-1:0] r_d_prod;
    logic [ROW_BITS-1:0]  r_d_row;
    logic [COL_BITS-1:0]  r_d_col;
    logic                 r_d_last;

    always_comb begin
        // forward the word written back in the same cycle the read was issued
        word   = i_s1.fwd ? i_s1.fwd_data : i_rd_data;
        above1 = (i_s1.row >= ROW_BITS'(1)) ? word[WORD_BITS-1 -: PIX_BITS] : '0;
        above2 = (i_s1.row >= ROW_BITS'(LINE_COUNT)) ? word[PIX_BITS-1:0] : '0;
        col_sum = CSUM_BITS'(above1) + CSUM_BITS'(above2) + CSUM_BITS'(i_s1.pix);
        o_mem_wr.en   = i_s1.vld;
        o_mem_wr.addr = i_s1.col;
        o_mem_wr.data = {i_s1.pix, word[WORD_BITS-1 -: PIX_BITS]};
    end

    // column sums of the two previous columns
    always_ff @(posedge i_clk) begin
        if (i_s1.vld) begin
            r_cs0 <= col_sum;
            r_cs1 <= r_cs0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_c_vld <= i_s1.vld & i_s1.has_res;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_sum  <= SUM_BITS'(col_sum) + SUM_BITS'(r_cs0) + SUM_BITS'(r_cs1) + ROUND_HALF;
        r_c_row  <= i_s1.row - ROW_BITS'(1);
        r_c_col  <= i_s1.col - COL_BITS'(1);
        r_c_last <= i_s1.last;
        r_d_prod <= PROD_BITS'(r_c_sum) * PROD_BITS'(RECIP_NINTH);
        r_d_row  <= r_c_row;
        r_d_col  <= r_c_col;
        r_d_last <= r_c_last;
    end

    always_comb begin
        o_push           = r_d_vld;
        o_res.mean       = r_d_prod[RECIP_SHIFT +: PIX_BITS];
        o_res.row        = r_d_row;
        o_res.col        = r_d_col;
        o_res.frame_done = r_d_last;
    end

endmodule

// File: sv/bmf_out_fifo.sv
// bmf_out_fifo: result queue in front of the output stream
// depends on bmf_pkg; never overfilled because the top level holds credits for it
module bmf_out_fifo
    import bmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_res
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr;
    logic [CNT_BITS-1:0]   r_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign pop     = i_pop & o_valid;
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CNT_BITS'(1);
                2'b01:   r_count <= r_count - CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/box_mean_filter_3x3.sv
// box_mean_filter_3x3: top level, raster position tracking, frame control and credits
// depends on bmf_pkg, bmf_line_mem, bmf_window, bmf_out_fifo
//
// channel   direction  signals                           word
// s         in         i_s_tvalid o_s_tready i_s_tdata   one pixel, tuser = frame start
//                      i_s_tuser
// m         out        o_m_tvalid i_m_tready o_m_tdata   one filtered interior pixel,
//                      o_m_tlast                         tlast = last of frame
// cfg       in         i_cfg_valid o_cfg_ready           register index and value
//                      i_cfg_index i_cfg_data
//
// one pixel per cycle while credits remain; results are registered at accept, sum and
// product and queued; line store read on accept, written back next cycle, sets the rate
// reset clears position, frame state, credits and queue; the line store is not cleared
// a stalled output only fills the 8-word result queue; input stalls once 8 results are owed
module box_mean_filter_3x3
    import bmf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [PIX_BITS-1:0]   i_s_tdata,   // [7:0] pixel_value
    input  logic [0:0]            i_s_tuser,   // [0] frame_start
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_BITS-1:0] o_m_tdata,   // [7:0] mean_value, [17:8] out_row,
                                               // [27:18] out_col, [31:28] zero
    output logic                  o_m_tlast,   // frame_done
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [DIM_BITS-1:0]   i_cfg_data
);

    logic [DIM_BITS-1:0] r_cfg_w;
    logic [DIM_BITS-1:0] r_cfg_h;
    logic [DIM_BITS-1:0] r_cur_w;
    logic [DIM_BITS-1:0] r_cur_h;
    logic [ROW_BITS-1:0] r_row;
    logic [COL_BITS-1:0] r_col;
    logic                r_active;
    logic [CNT_BITS-1:0] r_used;
    t_s1                 r_s1;

    logic [DIM_BITS-1:0] n_cur_w;
    logic [DIM_BITS-1:0] n_cur_h;
    logic [ROW_BITS-1:0] n_row;
    logic [COL_BITS-1:0] n_col;
    logic                n_active;
    t_s1                 n_s1;

    logic                accept;
    logic                fs;
    logic                act;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic [DIM_BITS-1:0] col_nx;
    logic [DIM_BITS-1:0] row_nx;
    logic                border;
    logic                has_res;
    logic                pop;

    t_mem_wr              mem_wr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 push;
    t_result              res_in;
    t_result              res_out;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_used < CNT_BITS'(FIFO_DEPTH));
    assign accept      = i_s_tvalid & o_s_tready;
    assign pop         = o_m_tvalid & i_m_tready;

    always_comb begin
        fs  = i_s_tuser[0];
        act = fs | r_active;
        w   = fs ? clamp_dim(r_cfg_w, WIDTH_MAX) : r_cur_w;
        h   = fs ? clamp_dim(r_cfg_h, HEIGHT_MAX) : r_cur_h;
        row = fs ? '0 : r_row;
        col = fs ? '0 : r_col;

        border = (row == '0) || (DIM_BITS'(row) == h - DIM_BITS'(1)) ||
                 (col == '0) || (DIM_BITS'(col) == w - DIM_BITS'(1));
        has_res = act && (row >= ROW_BITS'(LINE_COUNT)) && (col >= COL_BITS'(LINE_COUNT));

        col_nx   = DIM_BITS'(col) + DIM_BITS'(1);
        row_nx   = DIM_BITS'(row) + DIM_BITS'(1);
        n_cur_w  = w;
        n_cur_h  = h;
        n_active = act;
        n_row    = row;
        n_col    = col_nx[COL_BITS-1:0];
        if (col_nx >= w) begin
            n_col = '0;
            n_row = row_nx[ROW_BITS-1:0];
            if (row_nx >= h) begin
                n_row    = '0;
                n_active = 1'b0;
            end
        end

        n_s1.vld      = accept & act;
        n_s1.pix      = border ? '0 : i_s_tdata;
        n_s1.row      = row;
        n_s1.col      = col;
        n_s1.has_res  = has_res;
        n_s1.last     = (DIM_BITS'(row) == h - DIM_BITS'(1)) &&
                        (DIM_BITS'(col) == w - DIM_BITS'(1));
        // write back of the previous pixel lands on the entry being read
        n_s1.fwd      = mem_wr.en && (mem_wr.addr == col);
        n_s1.fwd_data = mem_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RST;
            r_cfg_h <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                default:          r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_w  <= clamp_dim(WIDTH_RST, WIDTH_MAX);
            r_cur_h  <= clamp_dim(HEIGHT_RST, HEIGHT_MAX);
            r_row    <= '0;
            r_col    <= '0;
            r_active <= 1'b1;
            r_s1     <= '0;
        end else begin
            if (accept && act) begin
                r_cur_w  <= n_cur_w;
                r_cur_h  <= n_cur_h;
                r_row    <= n_row;
                r_col    <= n_col;
                r_active <= n_active;
            end
            r_s1 <= n_s1;
        end
    end

    // credits: results owed, in flight or queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            case ({accept & has_res, pop})
                2'b10:   r_used <= r_used + CNT_BITS'(1);
                2'b01:   r_used <= r_used - CNT_BITS'(1);
                default: r_used <= r_used;
            endcase
        end
    end

    bmf_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (n_s1.vld),
        .i_rd_addr (col),
        .o_rd_data (rd_data)
    );

    bmf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (r_s1),
        .i_rd_data (rd_data),
        .o_mem_wr  (mem_wr),
        .o_push    (push),
        .o_res     (res_in)
    );

    bmf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res_in),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_res   (res_out)
    );

    assign o_m_tdata = {{(TDATA_BITS - COL_BITS - ROW_BITS - PIX_BITS){1'b0}},
                        res_out.col, res_out.row, res_out.mean};
    assign o_m_tlast = res_out.frame_done;

endmodule
